FILE: sv/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types, codes and constant tables for the CBOR certificate checker.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int MAX_BYTES_DEF     = 512;
  localparam int CALLSIGN_SIZE_DEF = 16;

  // Item index along the top-level array
  localparam logic [3:0] ITEM_ARRAY    = 4'd0;
  localparam logic [3:0] ITEM_MAGIC    = 4'd1;
  localparam logic [3:0] ITEM_VERSION  = 4'd2;
  localparam logic [3:0] ITEM_KIND     = 4'd3;
  localparam logic [3:0] ITEM_ALG      = 4'd4;
  localparam logic [3:0] ITEM_CALLSIGN = 4'd5;
  localparam logic [3:0] ITEM_UID      = 4'd6;
  localparam logic [3:0] ITEM_KEY      = 4'd7;
  localparam logic [3:0] ITEM_ISSUED   = 4'd8;
  localparam logic [3:0] ITEM_EXPIRES  = 4'd9;
  localparam logic [3:0] ITEM_SIG      = 4'd10;
  localparam logic [3:0] ITEM_DONE     = 4'd11;

  // Error codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_RESERVED  = 4'd1;
  localparam logic [3:0] ERR_TRUNC     = 4'd2;
  localparam logic [3:0] ERR_MAJOR     = 4'd3;
  localparam logic [3:0] ERR_COUNT     = 4'd4;
  localparam logic [3:0] ERR_MAGIC     = 4'd5;
  localparam logic [3:0] ERR_VERSION   = 4'd6;
  localparam logic [3:0] ERR_KIND      = 4'd7;
  localparam logic [3:0] ERR_OVER32    = 4'd8;
  localparam logic [3:0] ERR_CALLSIGN  = 4'd9;
  localparam logic [3:0] ERR_KEY_LEN   = 4'd10;
  localparam logic [3:0] ERR_SIG_LEN   = 4'd11;
  localparam logic [3:0] ERR_TRAILING  = 4'd12;
  localparam logic [3:0] ERR_TOO_LONG  = 4'd13;

  // CBOR major types
  localparam logic [2:0] MAJ_UINT  = 3'd0;
  localparam logic [2:0] MAJ_BYTES = 3'd2;
  localparam logic [2:0] MAJ_TEXT  = 3'd3;
  localparam logic [2:0] MAJ_ARRAY = 3'd4;

  localparam logic [4:0] INFO_EXT_MIN  = 5'd24;
  localparam logic [4:0] INFO_RSV_MIN  = 5'd28;

  localparam logic [63:0] ARRAY_ITEMS = 64'd10;
  localparam logic [63:0] MAGIC_LEN   = 64'd3;
  localparam logic [63:0] VERSION_NUM = 64'd4;
  localparam logic [63:0] KIND_LEN    = 64'd8;
  localparam logic [63:0] KEY_LEN     = 64'd32;
  localparam logic [63:0] SIG_LEN     = 64'd64;

  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_EXT  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic [3:0]  item;
    phase_t      phase;
    logic [3:0]  ext_left;
    logic [63:0] acc;
    logic [6:0]  content_left;
    logic        text_match;
    logic [3:0]  err;
    logic [31:0] uid;
    logic [31:0] alg;
    logic [63:0] issued;
    logic [63:0] expires;
  } cbc_state_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic [3:0]  field_tag;
    logic        is_payload;
    logic        signed_part;
    logic        done_res;
    logic        accepted;
    logic [3:0]  error_code;
    logic [31:0] uid_value;
    logic [31:0] algorithm_value;
    logic [63:0] issue_time;
    logic [63:0] expiry_time;
    logic [3:0]  callsign_length;
  } cbc_result_t;

  localparam cbc_state_t STATE_RESET = '{
    item:         ITEM_ARRAY,
    phase:        PH_HEAD,
    ext_left:     4'd0,
    acc:          64'd0,
    content_left: 7'd0,
    text_match:   1'b1,
    err:          ERR_NONE,
    uid:          32'd0,
    alg:          32'd0,
    issued:       64'd0,
    expires:      64'd0
  };

  function automatic logic [2:0] item_major(input logic [3:0] item);
    logic [2:0] m;
    case (item)
      ITEM_ARRAY:    m = MAJ_ARRAY;
      ITEM_MAGIC:    m = MAJ_TEXT;
      ITEM_KIND:     m = MAJ_TEXT;
      ITEM_CALLSIGN: m = MAJ_TEXT;
      ITEM_KEY:      m = MAJ_BYTES;
      ITEM_SIG:      m = MAJ_BYTES;
      default:       m = MAJ_UINT;
    endcase
    return m;
  endfunction

  // "FMO" magic text
  function automatic logic [7:0] magic_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = 8'h46;
      2'd1:    c = 8'h4D;
      2'd2:    c = 8'h4F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "userCert" kind text
  function automatic logic [7:0] kind_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h75;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h72;
      3'd4:    c = 8'h43;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h72;
      3'd7:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/cbc_step.sv
// ----------------------------------------------------------------------------
// cbc_step
// Per-byte parse step: next parser state and the result word for one byte.
// ----------------------------------------------------------------------------
module cbc_step #(
  parameter int MAX_BYTES     = cbc_pkg::MAX_BYTES_DEF,
  parameter int CALLSIGN_SIZE = cbc_pkg::CALLSIGN_SIZE_DEF,
  localparam int POS_W        = $clog2(MAX_BYTES + 1),
  localparam int CS_W         = $clog2(CALLSIGN_SIZE)
) (
  input  logic [7:0]          cert_byte,
  input  logic                is_last,
  input  cbc_pkg::cbc_state_t state_cur,
  input  logic [POS_W-1:0]    pos_cur,
  input  logic [CS_W-1:0]     cs_cur,
  output cbc_pkg::cbc_state_t state_nxt,
  output logic [POS_W-1:0]    pos_nxt,
  output logic [CS_W-1:0]     cs_nxt,
  output cbc_pkg::cbc_result_t result
);

  localparam int CSX_W = (CS_W > 4) ? CS_W : 4;

  always_comb begin
    cbc_pkg::cbc_state_t st;
    logic [POS_W-1:0] pos;
    logic [CS_W-1:0]  cs;
    logic [2:0]       major;
    logic [4:0]       info;
    logic             fin;
    logic             nxt_item;
    logic             start_body;
    logic [6:0]       body_len;
    logic [63:0]      v;
    logic [1:0]       mi;
    logic [2:0]       ki;
    logic             ok;
    logic             acc_ok;
    logic [CSX_W-1:0] cs_ext;

    st         = state_cur;
    pos        = pos_cur;
    cs         = cs_cur;
    major      = cert_byte[7:5];
    info       = cert_byte[4:0];
    fin        = 1'b0;
    nxt_item   = 1'b0;
    start_body = 1'b0;
    body_len   = 7'd0;
    v          = 64'd0;
    mi         = 2'(7'd3 - state_cur.content_left);
    ki         = 3'(7'd8 - state_cur.content_left);
    ok         = (state_cur.err == cbc_pkg::ERR_NONE);

    if (ok) begin
      if (pos_cur >= POS_W'(MAX_BYTES)) begin
        st.err = cbc_pkg::ERR_TOO_LONG;
      end else if (state_cur.item >= cbc_pkg::ITEM_DONE) begin
        st.err = cbc_pkg::ERR_TRAILING;
      end else begin
        case (state_cur.phase)
          cbc_pkg::PH_HEAD: begin
            if (info >= cbc_pkg::INFO_RSV_MIN) begin
              st.err = cbc_pkg::ERR_RESERVED;
            end else if (major != cbc_pkg::item_major(state_cur.item)) begin
              st.err = cbc_pkg::ERR_MAJOR;
            end else if (info < cbc_pkg::INFO_EXT_MIN) begin
              fin = 1'b1;
              v   = 64'(info);
            end else begin
              // 24..27 -> 1, 2, 4, 8 extended bytes
              st.ext_left = 4'd1 << info[1:0];
              st.acc      = 64'd0;
              st.phase    = cbc_pkg::PH_EXT;
            end
          end
          cbc_pkg::PH_EXT: begin
            st.acc      = {state_cur.acc[55:0], cert_byte};
            st.ext_left = state_cur.ext_left - 4'd1;
            if (st.ext_left == 4'd0) begin
              fin = 1'b1;
              v   = st.acc;
            end
          end
          cbc_pkg::PH_BODY: begin
            if (state_cur.item == cbc_pkg::ITEM_MAGIC) begin
              if (mi == 2'd3 || cbc_pkg::magic_char(mi) != cert_byte) st.text_match = 1'b0;
            end else if (state_cur.item == cbc_pkg::ITEM_KIND) begin
              if (cbc_pkg::kind_char(ki) != cert_byte) st.text_match = 1'b0;
            end
            st.content_left = state_cur.content_left - 7'd1;
            if (st.content_left == 7'd0) begin
              if (state_cur.item == cbc_pkg::ITEM_MAGIC && !st.text_match) begin
                st.err = cbc_pkg::ERR_MAGIC;
              end else if (state_cur.item == cbc_pkg::ITEM_KIND && !st.text_match) begin
                st.err = cbc_pkg::ERR_KIND;
              end else begin
                nxt_item = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end

    // Head complete: check the value against the item's rule
    if (fin) begin
      case (state_cur.item)
        cbc_pkg::ITEM_ARRAY: begin
          if (v != cbc_pkg::ARRAY_ITEMS) st.err = cbc_pkg::ERR_COUNT;
          else nxt_item = 1'b1;
        end
        cbc_pkg::ITEM_MAGIC: begin
          if (v != cbc_pkg::MAGIC_LEN) st.err = cbc_pkg::ERR_MAGIC;
          else begin
            start_body = 1'b1;
            body_len   = 7'(cbc_pkg::MAGIC_LEN);
          end
        end
        cbc_pkg::ITEM_VERSION: begin
          if (v != cbc_pkg::VERSION_NUM) st.err = cbc_pkg::ERR_VERSION;
          else nxt_item = 1'b1;
        end
        cbc_pkg::ITEM_KIND: begin
          if (v != cbc_pkg::KIND_LEN) st.err = cbc_pkg::ERR_KIND;
          else begin
            start_body = 1'b1;
            body_len   = 7'(cbc_pkg::KIND_LEN);
          end
        end
        cbc_pkg::ITEM_ALG: begin
          if (|v[63:32]) st.err = cbc_pkg::ERR_OVER32;
          else begin
            st.alg   = v[31:0];
            nxt_item = 1'b1;
          end
        end
        cbc_pkg::ITEM_CALLSIGN: begin
          if (v == 64'd0 || v >= 64'(CALLSIGN_SIZE)) st.err = cbc_pkg::ERR_CALLSIGN;
          else begin
            cs         = CS_W'(v);
            start_body = 1'b1;
            body_len   = 7'(v);
          end
        end
        cbc_pkg::ITEM_UID: begin
          if (|v[63:32]) st.err = cbc_pkg::ERR_OVER32;
          else begin
            st.uid   = v[31:0];
            nxt_item = 1'b1;
          end
        end
        cbc_pkg::ITEM_KEY: begin
          if (v != cbc_pkg::KEY_LEN) st.err = cbc_pkg::ERR_KEY_LEN;
          else begin
            start_body = 1'b1;
            body_len   = 7'(cbc_pkg::KEY_LEN);
          end
        end
        cbc_pkg::ITEM_ISSUED: begin
          st.issued = v;
          nxt_item  = 1'b1;
        end
        cbc_pkg::ITEM_EXPIRES: begin
          st.expires = v;
          nxt_item   = 1'b1;
        end
        cbc_pkg::ITEM_SIG: begin
          if (v != cbc_pkg::SIG_LEN) st.err = cbc_pkg::ERR_SIG_LEN;
          else begin
            start_body = 1'b1;
            body_len   = 7'(cbc_pkg::SIG_LEN);
          end
        end
        default: ;
      endcase
    end

    if (start_body) begin
      st.content_left = body_len;
      st.phase        = cbc_pkg::PH_BODY;
      st.text_match   = 1'b1;
    end
    if (nxt_item) begin
      st.item       = state_cur.item + 4'd1;
      st.phase      = cbc_pkg::PH_HEAD;
      st.text_match = 1'b1;
    end

    if (pos_cur < POS_W'(MAX_BYTES)) pos = pos_cur + POS_W'(1);

    if (is_last && st.err == cbc_pkg::ERR_NONE && st.item != cbc_pkg::ITEM_DONE) begin
      st.err = cbc_pkg::ERR_TRUNC;
    end

    acc_ok = is_last && (st.err == cbc_pkg::ERR_NONE);
    cs_ext = CSX_W'(cs);

    result.echo_byte       = cert_byte;
    result.field_tag       = state_cur.item;
    result.is_payload      = ok && (state_cur.item < cbc_pkg::ITEM_DONE)
                             && (state_cur.phase == cbc_pkg::PH_BODY);
    result.signed_part     = ok && (state_cur.item >= cbc_pkg::ITEM_MAGIC)
                             && (state_cur.item <= cbc_pkg::ITEM_EXPIRES);
    result.done_res        = is_last;
    result.accepted        = acc_ok;
    result.error_code      = is_last ? st.err : cbc_pkg::ERR_NONE;
    result.uid_value       = acc_ok ? st.uid : 32'd0;
    result.algorithm_value = acc_ok ? st.alg : 32'd0;
    result.issue_time      = acc_ok ? st.issued : 64'd0;
    result.expiry_time     = acc_ok ? st.expires : 64'd0;
    result.callsign_length = acc_ok ? cs_ext[3:0] : 4'd0;

    // Last byte closes the certificate; start clean for the next one
    if (is_last) begin
      st  = cbc_pkg::STATE_RESET;
      pos = '0;
      cs  = '0;
    end

    state_nxt = st;
    pos_nxt   = pos;
    cs_nxt    = cs;
  end

endmodule

FILE: sv/cbor_certificate_checker.sv
// ----------------------------------------------------------------------------
// cbor_certificate_checker
// Streaming layout check of a CBOR-encoded certificate, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one certificate byte per word,
//   in order, with in_is_last set on the final byte.
//   Result channel (out_valid/out_ready) returns exactly one word per input
//   byte: the echoed byte, its field tag and the payload / signed-span flags.
//   The word for the last byte also has out_done_res set and carries the
//   verdict: out_accepted, the first error code, and the decoded uid,
//   algorithm, issue/expiry times and callsign length (zero when rejected).
//   The parse step runs between the input ports and the result register.
//   Throughput is 1 byte per cycle while the result slot is free; the only
//   loop is the parser state register updated once per accepted byte.
//   When the receiver stalls, the held result keeps in_ready low only if a
//   new result could not be stored; a taken result frees the slot in the same
//   cycle, so back-to-back flow continues at full rate.
//   Reset (rst_n low, synchronous) empties the result register and puts the
//   parser at the array head; the last byte of a certificate resets the parser.
// ----------------------------------------------------------------------------
module cbor_certificate_checker #(
  parameter int MAX_BYTES     = cbc_pkg::MAX_BYTES_DEF,
  parameter int CALLSIGN_SIZE = cbc_pkg::CALLSIGN_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_cert_byte,
  input  logic        in_is_last,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_echo_byte,
  output logic [3:0]  out_field_tag,
  output logic        out_is_payload,
  output logic        out_signed_part,
  output logic        out_done_res,
  output logic        out_accepted,
  output logic [3:0]  out_error_code,
  output logic [31:0] out_uid_value,
  output logic [31:0] out_algorithm_value,
  output logic [63:0] out_issue_time,
  output logic [63:0] out_expiry_time,
  output logic [3:0]  out_callsign_length
);

  localparam int POS_W = $clog2(MAX_BYTES + 1);
  localparam int CS_W  = $clog2(CALLSIGN_SIZE);

  // Parser state
  cbc_pkg::cbc_state_t  state_r, state_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;      // bytes taken, saturates at MAX_BYTES
  logic [CS_W-1:0]      cs_r, cs_nxt;        // callsign length

  // Result register
  logic                 out_valid_r;
  cbc_pkg::cbc_result_t res_r, res_nxt;

  logic                 in_take;

  // Slot is free when empty or being drained this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign in_take  = in_valid && in_ready;

  cbc_step #(
    .MAX_BYTES     (MAX_BYTES),
    .CALLSIGN_SIZE (CALLSIGN_SIZE)
  ) u_step (
    .cert_byte (in_cert_byte),
    .is_last   (in_is_last),
    .state_cur (state_r),
    .pos_cur   (pos_r),
    .cs_cur    (cs_r),
    .state_nxt (state_nxt),
    .pos_nxt   (pos_nxt),
    .cs_nxt    (cs_nxt),
    .result    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbc_pkg::STATE_RESET;
      pos_r       <= '0;
      cs_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        state_r     <= state_nxt;
        pos_r       <= pos_nxt;
        cs_r        <= cs_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_echo_byte       = res_r.echo_byte;
  assign out_field_tag       = res_r.field_tag;
  assign out_is_payload      = res_r.is_payload;
  assign out_signed_part     = res_r.signed_part;
  assign out_done_res        = res_r.done_res;
  assign out_accepted        = res_r.accepted;
  assign out_error_code      = res_r.error_code;
  assign out_uid_value       = res_r.uid_value;
  assign out_algorithm_value = res_r.algorithm_value;
  assign out_issue_time      = res_r.issue_time;
  assign out_expiry_time     = res_r.expiry_time;
  assign out_callsign_length = res_r.callsign_length;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CBOR certificate checker: byte streams built as
// certificates (good, cut short, padded, broken at one item, plain noise) go
// through a valid/ready driver; a local parser predicts every result word,
// and the monitor compares them in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CERT_MAX_BYTES = cbc_pkg::MAX_BYTES_DEF;
  localparam int CALLSIGN_SLOTS = cbc_pkg::CALLSIGN_SIZE_DEF;

  // Ways a generated certificate can be broken at one chosen item
  typedef enum int {
    FLAW_NONE,
    FLAW_RESERVED,  // head byte with additional info 28..31
    FLAW_MAJOR,     // head byte with the wrong major type
    FLAW_VALUE,     // head value out of range for that item
    FLAW_TEXT       // one wrong character in the magic or kind text
  } cert_flaw_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cert_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_cert_byte;
  logic        in_is_last;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_echo_byte;
  logic [3:0]  out_field_tag;
  logic        out_is_payload;
  logic        out_signed_part;
  logic        out_done_res;
  logic        out_accepted;
  logic [3:0]  out_error_code;
  logic [31:0] out_uid_value;
  logic [31:0] out_algorithm_value;
  logic [63:0] out_issue_time;
  logic [63:0] out_expiry_time;
  logic [3:0]  out_callsign_length;

  // Layout tables, one entry per array item
  logic [2:0] major_by_item [0:10] = '{cbc_pkg::MAJ_ARRAY, cbc_pkg::MAJ_TEXT,
                                       cbc_pkg::MAJ_UINT, cbc_pkg::MAJ_TEXT,
                                       cbc_pkg::MAJ_UINT, cbc_pkg::MAJ_TEXT,
                                       cbc_pkg::MAJ_UINT, cbc_pkg::MAJ_BYTES,
                                       cbc_pkg::MAJ_UINT, cbc_pkg::MAJ_UINT,
                                       cbc_pkg::MAJ_BYTES};
  logic [7:0] magic_chars [0:2] = '{8'h46, 8'h4D, 8'h4F};
  logic [7:0] kind_chars [0:7] = '{8'h75, 8'h73, 8'h65, 8'h72, 8'h43, 8'h65, 8'h72, 8'h74};
  // Items whose head value can be out of range (times take any 64-bit value)
  logic [3:0] range_items [0:8] = '{cbc_pkg::ITEM_ARRAY, cbc_pkg::ITEM_MAGIC,
                                    cbc_pkg::ITEM_VERSION, cbc_pkg::ITEM_KIND,
                                    cbc_pkg::ITEM_ALG, cbc_pkg::ITEM_CALLSIGN,
                                    cbc_pkg::ITEM_UID, cbc_pkg::ITEM_KEY,
                                    cbc_pkg::ITEM_SIG};

  // Stimulus and scoreboard storage
  cert_word_t           send_q[$];      // words waiting for the driver
  cbc_pkg::cbc_result_t verdict_q[$];   // predicted result words, oldest first
  logic [7:0]           cert_buf[$];    // certificate under construction
  int                   words_queued;
  int                   words_taken;
  int                   fail_count;
  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  bit                   in_taken;       // set at the edge that took the current word

  // Shadow parser state
  int               cert_pos;
  logic [3:0]       cert_item;
  cbc_pkg::phase_t  cert_phase;
  logic [3:0]       ext_left;
  logic [63:0]      head_acc;
  logic [9:0]       body_left;
  logic             text_ok;
  logic [3:0]       first_err;
  logic [31:0]      kept_uid;
  logic [31:0]      kept_alg;
  logic [63:0]      kept_issued;
  logic [63:0]      kept_expires;
  logic [3:0]       kept_callsign;

  cbor_certificate_checker #(
    .MAX_BYTES     (CERT_MAX_BYTES),
    .CALLSIGN_SIZE (CALLSIGN_SLOTS)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cert_byte        (in_cert_byte),
    .in_is_last          (in_is_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_echo_byte       (out_echo_byte),
    .out_field_tag       (out_field_tag),
    .out_is_payload      (out_is_payload),
    .out_signed_part     (out_signed_part),
    .out_done_res        (out_done_res),
    .out_accepted        (out_accepted),
    .out_error_code      (out_error_code),
    .out_uid_value       (out_uid_value),
    .out_algorithm_value (out_algorithm_value),
    .out_issue_time      (out_issue_time),
    .out_expiry_time     (out_expiry_time),
    .out_callsign_length (out_callsign_length)
  );

  // --------------------------------------------------------------------------
  // Shadow parser: same walk over the layout as the block, one byte per call
  // --------------------------------------------------------------------------
  function automatic void clear_parser();
    cert_pos      = 0;
    cert_item     = cbc_pkg::ITEM_ARRAY;
    cert_phase    = cbc_pkg::PH_HEAD;
    ext_left      = '0;
    head_acc      = '0;
    body_left     = '0;
    text_ok       = 1'b1;
    first_err     = cbc_pkg::ERR_NONE;
    kept_uid      = '0;
    kept_alg      = '0;
    kept_issued   = '0;
    kept_expires  = '0;
    kept_callsign = '0;
  endfunction

  // Only the first error sticks
  function automatic void flag_err(input logic [3:0] code);
    if (first_err == cbc_pkg::ERR_NONE) first_err = code;
  endfunction

  function automatic void advance_item();
    cert_item  = cert_item + 4'd1;
    cert_phase = cbc_pkg::PH_HEAD;
    text_ok    = 1'b1;
  endfunction

  function automatic void open_body(input logic [9:0] len);
    body_left  = len;
    cert_phase = cbc_pkg::PH_BODY;
    text_ok    = 1'b1;
  endfunction

  // Head value complete: range check per item, store decoded numbers
  function automatic void close_head(input logic [63:0] v);
    case (cert_item)
      cbc_pkg::ITEM_ARRAY: begin
        if (v != cbc_pkg::ARRAY_ITEMS) flag_err(cbc_pkg::ERR_COUNT);
        else advance_item();
      end
      cbc_pkg::ITEM_MAGIC: begin
        if (v != cbc_pkg::MAGIC_LEN) flag_err(cbc_pkg::ERR_MAGIC);
        else open_body(10'(cbc_pkg::MAGIC_LEN));
      end
      cbc_pkg::ITEM_VERSION: begin
        if (v != cbc_pkg::VERSION_NUM) flag_err(cbc_pkg::ERR_VERSION);
        else advance_item();
      end
      cbc_pkg::ITEM_KIND: begin
        if (v != cbc_pkg::KIND_LEN) flag_err(cbc_pkg::ERR_KIND);
        else open_body(10'(cbc_pkg::KIND_LEN));
      end
      cbc_pkg::ITEM_ALG: begin
        if (v[63:32] != '0) flag_err(cbc_pkg::ERR_OVER32);
        else begin
          kept_alg = v[31:0];
          advance_item();
        end
      end
      cbc_pkg::ITEM_CALLSIGN: begin
        if (v == '0 || v >= 64'(CALLSIGN_SLOTS)) flag_err(cbc_pkg::ERR_CALLSIGN);
        else begin
          kept_callsign = v[3:0];
          open_body(v[9:0]);
        end
      end
      cbc_pkg::ITEM_UID: begin
        if (v[63:32] != '0) flag_err(cbc_pkg::ERR_OVER32);
        else begin
          kept_uid = v[31:0];
          advance_item();
        end
      end
      cbc_pkg::ITEM_KEY: begin
        if (v != cbc_pkg::KEY_LEN) flag_err(cbc_pkg::ERR_KEY_LEN);
        else open_body(10'(cbc_pkg::KEY_LEN));
      end
      cbc_pkg::ITEM_ISSUED: begin
        kept_issued = v;
        advance_item();
      end
      cbc_pkg::ITEM_EXPIRES: begin
        kept_expires = v;
        advance_item();
      end
      cbc_pkg::ITEM_SIG: begin
        if (v != cbc_pkg::SIG_LEN) flag_err(cbc_pkg::ERR_SIG_LEN);
        else open_body(10'(cbc_pkg::SIG_LEN));
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int idx;
    if (cert_item >= cbc_pkg::ITEM_DONE) begin
      flag_err(cbc_pkg::ERR_TRAILING);
    end else if (cert_phase == cbc_pkg::PH_HEAD) begin
      // reserved info wins over a wrong major type
      if (b[4:0] >= cbc_pkg::INFO_RSV_MIN) flag_err(cbc_pkg::ERR_RESERVED);
      else if (b[7:5] != major_by_item[cert_item]) flag_err(cbc_pkg::ERR_MAJOR);
      else if (b[4:0] < cbc_pkg::INFO_EXT_MIN) close_head({59'd0, b[4:0]});
      else begin
        ext_left   = 4'd1 << (b[4:0] - cbc_pkg::INFO_EXT_MIN);
        head_acc   = '0;
        cert_phase = cbc_pkg::PH_EXT;
      end
    end else if (cert_phase == cbc_pkg::PH_EXT) begin
      head_acc = {head_acc[55:0], b};
      ext_left = ext_left - 4'd1;
      if (ext_left == '0) close_head(head_acc);
    end else begin
      if (cert_item == cbc_pkg::ITEM_MAGIC) begin
        idx = (3 - int'(body_left)) & 3;
        if (idx >= 3 || magic_chars[idx] != b) text_ok = 1'b0;
      end else if (cert_item == cbc_pkg::ITEM_KIND) begin
        idx = (8 - int'(body_left)) & 7;
        if (kind_chars[idx] != b) text_ok = 1'b0;
      end
      body_left = body_left - 10'd1;
      if (body_left == '0) begin
        // text mismatches show up only once the whole string is in
        if (cert_item == cbc_pkg::ITEM_MAGIC && !text_ok) flag_err(cbc_pkg::ERR_MAGIC);
        else if (cert_item == cbc_pkg::ITEM_KIND && !text_ok) flag_err(cbc_pkg::ERR_KIND);
        else advance_item();
      end
    end
  endfunction

  // One accepted word in, one predicted result word queued
  function automatic void predict_word(input logic [7:0] b, input logic last);
    cbc_pkg::cbc_result_t r;
    logic                 clean;
    r     = '0;
    clean = (first_err == cbc_pkg::ERR_NONE);
    // tag and flags reflect the state on arrival, before this byte is parsed
    r.echo_byte   = b;
    r.field_tag   = (cert_item > cbc_pkg::ITEM_DONE) ? cbc_pkg::ITEM_DONE : cert_item;
    r.is_payload  = clean && cert_item < cbc_pkg::ITEM_DONE
                    && cert_phase == cbc_pkg::PH_BODY;
    r.signed_part = clean && cert_item >= cbc_pkg::ITEM_MAGIC
                    && cert_item <= cbc_pkg::ITEM_EXPIRES;
    if (first_err == cbc_pkg::ERR_NONE) begin
      if (cert_pos >= CERT_MAX_BYTES) flag_err(cbc_pkg::ERR_TOO_LONG);
      else parse_byte(b);
    end
    if (cert_pos < CERT_MAX_BYTES) cert_pos++;
    if (last && first_err == cbc_pkg::ERR_NONE && cert_item != cbc_pkg::ITEM_DONE) begin
      flag_err(cbc_pkg::ERR_TRUNC);
    end
    if (last) begin
      r.done_res   = 1'b1;
      r.accepted   = (first_err == cbc_pkg::ERR_NONE);
      r.error_code = first_err;
      if (first_err == cbc_pkg::ERR_NONE) begin
        r.uid_value       = kept_uid;
        r.algorithm_value = kept_alg;
        r.issue_time      = kept_issued;
        r.expiry_time     = kept_expires;
        r.callsign_length = kept_callsign;
      end
      clear_parser();
    end
    verdict_q.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Certificate builder
  // --------------------------------------------------------------------------
  // Random value, magnitude spread over 0..max_bits bits, all-ones now and then
  function automatic logic [63:0] rand_wide(input int max_bits);
    int          w;
    logic [63:0] mask;
    logic [63:0] v;
    w    = $urandom_range(max_bits, 0);
    mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    v    = {$urandom, $urandom} & mask;
    if ($urandom_range(7) == 0) v = mask;
    return v;
  endfunction

  // Head in the shortest form most of the time, else any form no shorter than that
  function automatic void put_head(input logic [2:0] maj, input logic [63:0] v);
    int lo;
    int form;
    int n;
    if (v < 64'd24) lo = 0;
    else if (v < 64'd256) lo = 1;
    else if (v < 64'd65536) lo = 2;
    else if (v < 64'h1_0000_0000) lo = 3;
    else lo = 4;
    form = ($urandom_range(99) < 60) ? lo : int'($urandom_range(4, lo));
    if (form == 0) begin
      cert_buf.push_back({maj, v[4:0]});
    end else begin
      cert_buf.push_back({maj, 5'(cbc_pkg::INFO_EXT_MIN + form - 1)});
      n = 1 << (form - 1);
      for (int i = n - 1; i >= 0; i--) cert_buf.push_back(v[8*i +: 8]);
    end
  endfunction

  // Head value the layout rejects for this item
  function automatic logic [63:0] bad_value(input int k);
    logic [3:0]  kit;
    logic [63:0] good;
    logic [63:0] v;
    kit = 4'(k);
    case (kit)
      cbc_pkg::ITEM_ARRAY:   good = cbc_pkg::ARRAY_ITEMS;
      cbc_pkg::ITEM_MAGIC:   good = cbc_pkg::MAGIC_LEN;
      cbc_pkg::ITEM_VERSION: good = cbc_pkg::VERSION_NUM;
      cbc_pkg::ITEM_KIND:    good = cbc_pkg::KIND_LEN;
      cbc_pkg::ITEM_KEY:     good = cbc_pkg::KEY_LEN;
      default:               good = cbc_pkg::SIG_LEN;
    endcase
    if (kit == cbc_pkg::ITEM_ALG || kit == cbc_pkg::ITEM_UID) begin
      v = rand_wide(64);
      if (v[63:32] == '0) v[32 + $urandom_range(31)] = 1'b1;
    end else if (kit == cbc_pkg::ITEM_CALLSIGN) begin
      case ($urandom_range(2))
        0:       v = '0;
        1:       v = 64'(CALLSIGN_SLOTS + $urandom_range(3));
        default: v = rand_wide(64) | 64'(CALLSIGN_SLOTS);
      endcase
    end else begin
      v = $urandom_range(1) ? (good ^ (64'd1 << $urandom_range(63))) : rand_wide(64);
      if (v == good) v = good + 64'd1;
    end
    return v;
  endfunction

  // Well-formed certificate, optionally broken at bad_item; a broken one
  // stops shortly after the break since the rest is never parsed
  function automatic void build_cert(input int bad_item, input cert_flaw_t flaw);
    logic [2:0]  maj;
    logic [3:0]  kit;
    logic [63:0] v;
    int          n;
    int          idx;
    bit          stop;
    stop = 1'b0;
    for (int k = 0; k <= 10; k++) begin
      if (!stop) begin
        kit = 4'(k);
        maj = major_by_item[k];
        case (kit)
          cbc_pkg::ITEM_ARRAY:   v = cbc_pkg::ARRAY_ITEMS;
          cbc_pkg::ITEM_MAGIC:   v = cbc_pkg::MAGIC_LEN;
          cbc_pkg::ITEM_VERSION: v = cbc_pkg::VERSION_NUM;
          cbc_pkg::ITEM_KIND:    v = cbc_pkg::KIND_LEN;
          cbc_pkg::ITEM_ALG, cbc_pkg::ITEM_UID: v = rand_wide(32);
          cbc_pkg::ITEM_CALLSIGN: v = 64'($urandom_range(CALLSIGN_SLOTS - 1, 1));
          cbc_pkg::ITEM_KEY:     v = cbc_pkg::KEY_LEN;
          cbc_pkg::ITEM_ISSUED, cbc_pkg::ITEM_EXPIRES: v = rand_wide(64);
          default:               v = cbc_pkg::SIG_LEN;
        endcase
        if (k == bad_item && flaw == FLAW_RESERVED) begin
          cert_buf.push_back({3'($urandom), 5'($urandom_range(31, 28))});
          stop = 1'b1;
        end else if (k == bad_item && flaw == FLAW_MAJOR) begin
          put_head(maj ^ 3'($urandom_range(7, 1)), v);
          stop = 1'b1;
        end else if (k == bad_item && flaw == FLAW_VALUE) begin
          put_head(maj, bad_value(k));
          stop = 1'b1;
        end else begin
          put_head(maj, v);
          if (maj == cbc_pkg::MAJ_TEXT || maj == cbc_pkg::MAJ_BYTES) begin
            n = cert_buf.size();
            for (int i = 0; i < int'(v); i++) begin
              if (kit == cbc_pkg::ITEM_MAGIC) cert_buf.push_back(magic_chars[i]);
              else if (kit == cbc_pkg::ITEM_KIND) cert_buf.push_back(kind_chars[i]);
              else cert_buf.push_back(8'($urandom));
            end
            if (k == bad_item && flaw == FLAW_TEXT) begin
              idx = $urandom_range(int'(v) - 1);
              cert_buf[n + idx] = cert_buf[n + idx] ^ 8'($urandom_range(255, 1));
              stop = 1'b1;
            end
          end
        end
      end
    end
    if (stop) repeat ($urandom_range(3)) cert_buf.push_back(8'($urandom));
  endfunction

  // Hand the built certificate to the driver, last flag on its final byte
  function automatic void flush_cert();
    for (int i = 0; i < cert_buf.size(); i++)
      send_q.push_back('{data: cert_buf[i], last: (i == cert_buf.size() - 1)});
    words_queued += cert_buf.size();
    cert_buf.delete();
  endfunction

  // Random certificates until about 'target' bytes are queued
  function automatic void fill_random(input int target);
    int         added;
    int         pick;
    int         bad;
    int         cut;
    cert_flaw_t flaw;
    added = 0;
    while (added < target) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        build_cert(-1, FLAW_NONE);
      end else if (pick < 40) begin
        // bytes past the signature
        build_cert(-1, FLAW_NONE);
        repeat ($urandom_range(4, 1)) cert_buf.push_back(8'($urandom));
      end else if (pick < 50) begin
        // last flag arrives early
        build_cert(-1, FLAW_NONE);
        cut = $urandom_range(cert_buf.size() - 1, 1);
        cert_buf = cert_buf[0:cut-1];
      end else if (pick < 90) begin
        flaw = cert_flaw_t'($urandom_range(FLAW_TEXT, FLAW_RESERVED));
        case (flaw)
          FLAW_TEXT:  bad = $urandom_range(1) ? int'(cbc_pkg::ITEM_MAGIC)
                                              : int'(cbc_pkg::ITEM_KIND);
          FLAW_VALUE: bad = int'(range_items[$urandom_range(8)]);
          default:    bad = $urandom_range(cbc_pkg::ITEM_SIG, cbc_pkg::ITEM_ARRAY);
        endcase
        build_cert(bad, flaw);
      end else begin
        // short noise burst
        repeat ($urandom_range(6, 1)) cert_buf.push_back(8'($urandom));
      end
      added += cert_buf.size();
      flush_cert();
    end
  endfunction

  // Sender holds off until every queued word has its result back
  task automatic wait_drained();
    do @(negedge clk); while (words_taken != words_queued || verdict_q.size() != 0);
    @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: new word at the falling edge once the previous one was taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : driver
    cert_word_t w;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = send_q.pop_front();
          in_valid     <= 1'b1;
          in_cert_byte <= w.data;
          in_is_last   <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input handshakes, compare on output handshakes
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    cbc_pkg::cbc_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_word(in_cert_byte, in_is_last);
        words_taken++;
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result word with nothing expected, echo_byte %0h", out_echo_byte);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          check_field("echo_byte", 64'(want.echo_byte), 64'(out_echo_byte));
          check_field("field_tag", 64'(want.field_tag), 64'(out_field_tag));
          check_field("is_payload", 64'(want.is_payload), 64'(out_is_payload));
          check_field("signed_part", 64'(want.signed_part), 64'(out_signed_part));
          check_field("done_res", 64'(want.done_res), 64'(out_done_res));
          check_field("accepted", 64'(want.accepted), 64'(out_accepted));
          check_field("error_code", 64'(want.error_code), 64'(out_error_code));
          check_field("uid_value", 64'(want.uid_value), 64'(out_uid_value));
          check_field("algorithm_value", 64'(want.algorithm_value),
                      64'(out_algorithm_value));
          check_field("issue_time", want.issue_time, out_issue_time);
          check_field("expiry_time", want.expiry_time, out_expiry_time);
          check_field("callsign_length", 64'(want.callsign_length),
                      64'(out_callsign_length));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed certificates, then three random phases with
  // different idle patterns, each drained before the next one starts
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cert_byte  = '0;
    in_is_last    = 1'b0;
    out_ready     = 1'b0;
    in_taken      = 1'b0;
    words_queued  = 0;
    words_taken   = 0;
    fail_count    = 0;
    send_idle_pct = 27;
    recv_idle_pct = 46;
    clear_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // good array head, then the stream ends
    cert_buf = '{8'h8A};
    flush_cert();
    // reserved info with major 7: reserved is reported, not the major
    cert_buf = '{8'hFC};
    flush_cert();
    // indefinite-length array head (info 31)
    cert_buf = '{8'h9F};
    flush_cert();
    // unsigned where the array head belongs
    cert_buf = '{8'h0A};
    flush_cert();
    // array of 9
    cert_buf = '{8'h89};
    flush_cert();
    // count 10 in the 1-byte and 8-byte forms, then cut short
    cert_buf = '{8'h98, 8'h0A};
    flush_cert();
    cert_buf = '{8'h9B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0A};
    flush_cert();
    // magic text with a bad last character, one frozen byte after it
    cert_buf = '{8'h8A, 8'h63, 8'h46, 8'h4D, 8'h58, 8'hFF};
    flush_cert();
    // magic text of length 2, error on the byte marked last
    cert_buf = '{8'h8A, 8'h62};
    flush_cert();
    // all-ones byte then all-zeros byte
    cert_buf = '{8'hFF, 8'h00};
    flush_cert();

    fill_random(300);
    wait_drained();

    send_idle_pct = 46;
    recv_idle_pct = 27;
    fill_random(300);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(300);
    wait_drained();

    // spare cycles at the end catch any stray result word
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
